// ----- hw/rtl/tij_pkg.sv -----
// shared types, opcodes, register addresses and the timer period table
// for the timer, interrupt and joypad i/o unit; no dependencies
package tij_pkg;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_BUTTON = 3'd3;
   localparam logic [2:0] OP_CHECK  = 3'd4;

   localparam logic [7:0] ADDR_JOYP = 8'h00;
   localparam logic [7:0] ADDR_DIV  = 8'h04;
   localparam logic [7:0] ADDR_TIMA = 8'h05;
   localparam logic [7:0] ADDR_TMA  = 8'h06;
   localparam logic [7:0] ADDR_TAC  = 8'h07;
   localparam logic [7:0] ADDR_IF   = 8'h0F;
   localparam logic [7:0] ADDR_IE   = 8'hFF;

   localparam logic [7:0] JOYP_FIXED  = 8'hCF;
   localparam logic [7:0] TAC_FILL    = 8'hF8;
   localparam logic [7:0] IF_FILL     = 8'hE0;
   localparam logic [7:0] UNMAPPED    = 8'hFF;
   localparam logic [6:0] VECTOR_BASE = 7'h40;

   localparam int unsigned IRQ_TIMER  = 2;
   localparam int unsigned IRQ_JOYPAD = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP,
      ST_DONE
   } tij_state_type;

   // result of one pass through the shared timer step unit
   typedef struct packed {
      logic        ge;
      logic [11:0] acc_next;
      logic [7:0]  count_next;
      logic        overflow;
   } tij_step_type;

   // interrupt selection result
   typedef struct packed {
      logic       pending;
      logic       taken;
      logic [6:0] vector;
      logic [4:0] clear;
   } tij_irq_type;

   function automatic logic [10:0] timer_period(input logic [1:0] sel);
      logic [10:0] p;
      unique case (sel)
         2'd0: p = 11'd1024;
         2'd1: p = 11'd16;
         2'd2: p = 11'd64;
         2'd3: p = 11'd256;
         default: p = 11'd1024;
      endcase
      return p;
   endfunction

endpackage

// ----- hw/rtl/timer_irq_joypad_io_unit.sv -----
// timer, interrupt and joypad i/o unit: an accepted request goes through the exec state,
// then, for an enabled tick, stays in the step state until the accumulator is below the
// period (one step per cycle through the shared unit), then the done state writes the
// output register once it is free; a new request is taken only once the sequencer is back
// in idle; a finished result waits in the output register without blocking idle
// synchronous active-high reset clears all timer, interrupt and joypad state, select = 2'b11
module timer_irq_joypad_io_unit import tij_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] step_cycles, [6] vblank_request, [7] stat_request, [15:8] reg_address,
   // [23:16] write_data, [31:24] button_bits, [32] master_enable, [39:33] zero
   input  logic [39:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] irq_pending, [9] irq_taken, [16:10] irq_vector, [23:17] zero
   output logic [23:0] rsp_tdata
);

   tij_state_type state_ff, state_in;

   // latched request
   logic [2:0] op_ff, op_in;
   logic [5:0] cycles_ff, cycles_in;
   logic       vbl_ff, vbl_in;
   logic       stat_ff, stat_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] wdata_ff, wdata_in;
   logic [7:0] btn_ff, btn_in;
   logic       ime_ff, ime_in;

   // architectural state
   logic [15:0] div_ff, div_in;
   logic [7:0]  tima_ff, tima_in;
   logic [7:0]  tma_ff, tma_in;
   logic [2:0]  tac_ff, tac_in;
   logic [10:0] accum_ff, accum_in;
   logic [4:0]  flags_ff, flags_in;
   logic [7:0]  ie_ff, ie_in;
   logic [1:0]  sel_ff, sel_in;
   logic [7:0]  pad_ff, pad_in;

   // working accumulator of the step loop
   logic [11:0] acc_ff, acc_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rdata_ff, rdata_in;
   logic       pend_ff, pend_in;
   logic       taken_ff, taken_in;
   logic [6:0] vector_ff, vector_in;

   logic         out_free;
   logic [4:0]   flags_eff;
   logic [7:0]   rd_value;
   logic [7:0]   joyp;
   tij_step_type step;
   tij_irq_type  irq;

   tij_timer_unit u_timer (
      .acc    (acc_ff),
      .period (timer_period(tac_ff[1:0])),
      .count  (tima_ff),
      .reload (tma_ff),
      .step   (step)
   );

   // video requests join the flags after the timer steps of the tick
   assign flags_eff = flags_ff | ((op_ff == OP_TICK) ? {3'b000, stat_ff, vbl_ff} : 5'b00000);

   tij_irq_unit u_irq (
      .flags         (flags_eff),
      .enables       (ie_ff),
      .check         (op_ff == OP_CHECK),
      .master_enable (ime_ff),
      .irq           (irq)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, vector_ff, taken_ff, pend_ff, rdata_ff};

   // joypad read: pressed lines of a selected group pull the low nibble down
   always_comb begin
      joyp = JOYP_FIXED | {2'b00, sel_ff, 4'b0000};
      if (!sel_ff[0]) begin
         joyp[3:0] = joyp[3:0] & ~pad_ff[3:0];
      end
      if (!sel_ff[1]) begin
         joyp[3:0] = joyp[3:0] & ~pad_ff[7:4];
      end
   end

   // register read mux
   always_comb begin
      unique case (addr_ff)
         ADDR_JOYP: rd_value = joyp;
         ADDR_DIV:  rd_value = div_ff[15:8];
         ADDR_TIMA: rd_value = tima_ff;
         ADDR_TMA:  rd_value = tma_ff;
         ADDR_TAC:  rd_value = TAC_FILL | {5'b00000, tac_ff};
         ADDR_IF:   rd_value = IF_FILL | {3'b000, flags_ff};
         ADDR_IE:   rd_value = ie_ff;
         default:   rd_value = UNMAPPED;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ((op_ff == OP_TICK) && tac_ff[2]) ? ST_STEP : ST_DONE;
         end
         ST_STEP: begin
            state_in = step.ge ? ST_STEP : ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in        = op_ff;
      cycles_in    = cycles_ff;
      vbl_in       = vbl_ff;
      stat_in      = stat_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      btn_in       = btn_ff;
      ime_in       = ime_ff;
      div_in       = div_ff;
      tima_in      = tima_ff;
      tma_in       = tma_ff;
      tac_in       = tac_ff;
      accum_in     = accum_ff;
      flags_in     = flags_ff;
      ie_in        = ie_ff;
      sel_in       = sel_ff;
      pad_in       = pad_ff;
      acc_in       = acc_ff;
      rdata_in     = rdata_ff;
      pend_in      = pend_ff;
      taken_in     = taken_ff;
      vector_in    = vector_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               cycles_in = req_tdata[5:0];
               vbl_in    = req_tdata[6];
               stat_in   = req_tdata[7];
               addr_in   = req_tdata[15:8];
               wdata_in  = req_tdata[23:16];
               btn_in    = req_tdata[31:24];
               ime_in    = req_tdata[32];
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_TICK: begin
                  div_in = div_ff + {10'd0, cycles_ff};
                  acc_in = {1'b0, accum_ff} + {6'd0, cycles_ff};
               end
               OP_WRITE: begin
                  unique case (addr_ff)
                     ADDR_JOYP: sel_in   = wdata_ff[5:4];
                     ADDR_DIV:  div_in   = '0;
                     ADDR_TIMA: tima_in  = wdata_ff;
                     ADDR_TMA:  tma_in   = wdata_ff;
                     ADDR_TAC:  tac_in   = wdata_ff[2:0];
                     ADDR_IF:   flags_in = wdata_ff[4:0];
                     ADDR_IE:   ie_in    = wdata_ff;
                     default:   ;
                  endcase
               end
               OP_BUTTON: begin
                  // joypad interrupt on any newly pressed button
                  if ((~pad_ff & btn_ff) != 8'd0) begin
                     flags_in[IRQ_JOYPAD] = 1'b1;
                  end
                  pad_in = btn_ff;
               end
               default: ;
            endcase
         end
         ST_STEP: begin
            // one timer period per cycle until the accumulator falls below it
            if (step.ge) begin
               acc_in  = step.acc_next;
               tima_in = step.count_next;
               if (step.overflow) begin
                  flags_in[IRQ_TIMER] = 1'b1;
               end
            end else begin
               accum_in = acc_ff[10:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rdata_in     = (op_ff == OP_READ) ? rd_value : 8'd0;
               pend_in      = irq.pending;
               taken_in     = irq.taken;
               vector_in    = irq.vector;
               flags_in     = flags_eff & ~irq.clear;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_ff       <= '0;
         tima_ff      <= '0;
         tma_ff       <= '0;
         tac_ff       <= '0;
         accum_ff     <= '0;
         flags_ff     <= '0;
         ie_ff        <= '0;
         sel_ff       <= 2'b11;
         pad_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_ff       <= div_in;
         tima_ff      <= tima_in;
         tma_ff       <= tma_in;
         tac_ff       <= tac_in;
         accum_ff     <= accum_in;
         flags_ff     <= flags_in;
         ie_ff        <= ie_in;
         sel_ff       <= sel_in;
         pad_ff       <= pad_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cycles_ff <= cycles_in;
      vbl_ff    <= vbl_in;
      stat_ff   <= stat_in;
      addr_ff   <= addr_in;
      wdata_ff  <= wdata_in;
      btn_ff    <= btn_in;
      ime_ff    <= ime_in;
      acc_ff    <= acc_in;
      rdata_ff  <= rdata_in;
      pend_ff   <= pend_in;
      taken_ff  <= taken_in;
      vector_ff <= vector_in;
   end

endmodule

// ----- hw/rtl/tij_timer_unit.sv -----
// shared compare, subtract and increment unit for the timer sequencer
// depends on tij_pkg
module tij_timer_unit import tij_pkg::*; (
   input  logic [11:0]  acc,
   input  logic [10:0]  period,
   input  logic [7:0]   count,
   input  logic [7:0]   reload,
   output tij_step_type step
);

   logic [7:0] inc;

   always_comb begin
      inc             = count + 8'd1;
      step.ge         = acc >= {1'b0, period};
      step.acc_next   = acc - {1'b0, period};
      step.overflow   = (inc == 8'd0);
      step.count_next = step.overflow ? reload : inc;
   end

endmodule

// ----- hw/rtl/tij_irq_unit.sv -----
// pending test and lowest-index interrupt selection
// depends on tij_pkg
module tij_irq_unit import tij_pkg::*; (
   input  logic [4:0]  flags,
   input  logic [7:0]  enables,
   input  logic        check,
   input  logic        master_enable,
   output tij_irq_type irq
);

   logic [4:0] pend;

   always_comb begin
      pend        = flags & enables[4:0];
      irq.pending = |pend;
      irq.taken   = check && master_enable && irq.pending;
      irq.vector  = '0;
      irq.clear   = '0;
      if (irq.taken) begin
         priority if (pend[0]) begin
            irq.vector = VECTOR_BASE;
            irq.clear  = 5'b00001;
         end else if (pend[1]) begin
            irq.vector = VECTOR_BASE + 7'd8;
            irq.clear  = 5'b00010;
         end else if (pend[2]) begin
            irq.vector = VECTOR_BASE + 7'd16;
            irq.clear  = 5'b00100;
         end else if (pend[3]) begin
            irq.vector = VECTOR_BASE + 7'd24;
            irq.clear  = 5'b01000;
         end else begin
            irq.vector = VECTOR_BASE + 7'd32;
            irq.clear  = 5'b10000;
         end
      end
   end

endmodule

// ----- hw/rtl/tij_checker.sv -----
// port-level checks for timer_irq_joypad_io_unit and the bind that attaches them
// depends on the top level's port list only
module tij_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one request at a time: not ready right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a request was accepted");

   // a taken interrupt is always a pending one
   a_taken_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8])
      else $error("interrupt taken without pending");

   // taken gives one of the five vectors, otherwise the vector is zero
   a_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9] ?
         (rsp_tdata[16:10] == 7'h40 || rsp_tdata[16:10] == 7'h48 ||
          rsp_tdata[16:10] == 7'h50 || rsp_tdata[16:10] == 7'h58 ||
          rsp_tdata[16:10] == 7'h60) : (rsp_tdata[16:10] == 7'h00)))
      else $error("bad interrupt vector");

endmodule

bind timer_irq_joypad_io_unit tij_checker u_tij_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/timer_irq_joypad_io_checker.sv -----
// response checker for the timer, interrupt and joypad i/o unit: watches both
// stream channels, predicts each response and compares it field by field
// depends on tij_pkg for opcodes, register addresses and fixed bit patterns
module timer_irq_joypad_io_checker import tij_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [5:0] step_cycles, [6] vblank_request, [7] stat_request, [15:8] reg_address,
   // [23:16] write_data, [31:24] button_bits, [32] master_enable, [39:33] zero
   input  logic [39:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] irq_pending, [9] irq_taken, [16:10] irq_vector, [23:17] zero
   input  logic [23:0] rsp_tdata,
   output int unsigned error_count,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_PRINTED = 40;

   // last member sits in the lowest bits, matching the response layout
   typedef struct packed {
      logic [6:0] irq_vector;
      logic       irq_taken;
      logic       irq_pending;
      logic [7:0] read_data;
   } io_result_t;

   // predicted register file
   logic [15:0] div_count;
   logic [7:0]  tima;
   logic [7:0]  tma;
   logic [2:0]  tac;
   logic [10:0] accum;
   logic [4:0]  if_bits;
   logic [7:0]  ie_bits;
   logic [1:0]  joy_select;
   logic [7:0]  buttons_held;

   io_result_t  expected_responses[$];
   io_result_t  got;
   io_result_t  want;
   int unsigned mismatches = 0;
   int unsigned response_index = 0;

   task automatic report_mismatch(input string what, input logic [7:0] seen,
                                  input logic [7:0] predicted);
      if (mismatches < MAX_PRINTED)
         $display("%t: response %0d %s: got %0h, predicted %0h",
                  $realtime, response_index, what, seen, predicted);
      mismatches++;
   endtask

   task automatic clear_registers();
      div_count    = '0;
      tima         = '0;
      tma          = '0;
      tac          = '0;
      accum        = '0;
      if_bits      = '0;
      ie_bits      = '0;
      joy_select   = 2'b11;
      buttons_held = '0;
   endtask

   task automatic advance_timer(input logic [5:0] cycles);
      int unsigned acc;
      int unsigned period;
      div_count = div_count + 16'(cycles);
      if (tac[2]) begin
         case (tac[1:0])
            2'd0: period = 1024;
            2'd1: period = 16;
            2'd2: period = 64;
            default: period = 256;
         endcase
         acc = accum + cycles;
         // a period change can leave several whole periods in the accumulator
         while (acc >= period) begin
            acc -= period;
            tima = tima + 8'd1;
            if (tima == 8'd0) begin
               tima = tma;
               if_bits[IRQ_TIMER] = 1'b1;
            end
         end
         accum = acc[10:0];
      end
   endtask

   function automatic logic [7:0] register_value(input logic [7:0] addr);
      logic [7:0] v;
      case (addr)
         ADDR_JOYP: begin
            v = JOYP_FIXED | {2'b00, joy_select, 4'h0};
            if (!joy_select[0]) v[3:0] = v[3:0] & ~buttons_held[3:0];
            if (!joy_select[1]) v[3:0] = v[3:0] & ~buttons_held[7:4];
         end
         ADDR_DIV:  v = div_count[15:8];
         ADDR_TIMA: v = tima;
         ADDR_TMA:  v = tma;
         ADDR_TAC:  v = TAC_FILL | {5'b0, tac};
         ADDR_IF:   v = IF_FILL | {3'b0, if_bits};
         ADDR_IE:   v = ie_bits;
         default:   v = UNMAPPED;
      endcase
      return v;
   endfunction

   task automatic register_store(input logic [7:0] addr, input logic [7:0] value);
      case (addr)
         ADDR_JOYP: joy_select = value[5:4];
         ADDR_DIV:  div_count = '0;   // accumulator is left alone
         ADDR_TIMA: tima = value;
         ADDR_TMA:  tma = value;
         ADDR_TAC:  tac = value[2:0];
         ADDR_IF:   if_bits = value[4:0];
         ADDR_IE:   ie_bits = value;
         default: ;
      endcase
   endtask

   task automatic predict_io_result(input logic [2:0] op, input logic [39:0] d,
                                    output io_result_t res);
      logic [4:0] pend;
      res = '0;
      case (op)
         OP_TICK: begin
            advance_timer(d[5:0]);
            // video requests land after the timer step
            if (d[6]) if_bits[0] = 1'b1;
            if (d[7]) if_bits[1] = 1'b1;
         end
         OP_READ:  res.read_data = register_value(d[15:8]);
         OP_WRITE: register_store(d[15:8], d[23:16]);
         OP_BUTTON: begin
            if ((~buttons_held & d[31:24]) != 8'h00) if_bits[IRQ_JOYPAD] = 1'b1;
            buttons_held = d[31:24];
         end
         default: ;
      endcase
      pend = if_bits & ie_bits[4:0];
      res.irq_pending = |pend;
      if (op == OP_CHECK && d[32] && pend != 5'b0) begin
         for (int i = 0; i < 5; i++) begin
            if (pend[i] && !res.irq_taken) begin
               if_bits[i] = 1'b0;
               res.irq_taken = 1'b1;
               res.irq_vector = VECTOR_BASE + 7'(8 * i);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_registers();
         expected_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[16:0];
            if (expected_responses.size() == 0) begin
               report_mismatch("with no request waiting", got.read_data, 8'h00);
            end else begin
               want = expected_responses.pop_front();
               if (got.read_data !== want.read_data)
                  report_mismatch("read_data", got.read_data, want.read_data);
               if (got.irq_pending !== want.irq_pending)
                  report_mismatch("irq_pending", 8'(got.irq_pending), 8'(want.irq_pending));
               if (got.irq_taken !== want.irq_taken)
                  report_mismatch("irq_taken", 8'(got.irq_taken), 8'(want.irq_taken));
               if (got.irq_vector !== want.irq_vector)
                  report_mismatch("irq_vector", 8'(got.irq_vector), 8'(want.irq_vector));
            end
            response_index++;
         end
         if (req_tvalid && req_tready) begin
            predict_io_result(req_tuser, req_tdata, want);
            expected_responses.push_back(want);
         end
      end
      error_count <= mismatches;
      outstanding <= expected_responses.size();
   end

endmodule

// ----- sim/tb_timer_irq_joypad_io_unit.sv -----
// testbench top for the timer, interrupt and joypad i/o unit: clock, reset,
// directed and random request stimulus, response back-pressure and the verdict
// depends on tij_pkg, timer_irq_joypad_io_unit and timer_irq_joypad_io_checker
module tb_timer_irq_joypad_io_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tij_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1950;
   // enabled tick worst case is a full run of timer steps plus a long response stall
   localparam int unsigned DRAIN_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // see the port list of the unit for the field layout
   logic [2:0]  req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   int unsigned error_count;
   int unsigned outstanding;
   bit          steady = 1'b0;   // set for stretches with no idling on either side

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   timer_irq_joypad_io_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   timer_irq_joypad_io_checker io_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one request and hold it until the unit takes it, then maybe idle
   task automatic send_request(input logic [2:0] op, input logic [39:0] fields);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= fields;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // fields the opcode does not use get random filler so their bits toggle
   function automatic logic [39:0] filler();
      logic [39:0] f;
      f = 40'({$urandom, $urandom});
      f[39:33] = '0;
      return f;
   endfunction

   task automatic tick(input logic [5:0] cycles, input logic vbl, input logic stat);
      logic [39:0] f;
      f = filler();
      f[5:0] = cycles;
      f[6] = vbl;
      f[7] = stat;
      send_request(OP_TICK, f);
   endtask

   task automatic read_reg(input logic [7:0] addr);
      logic [39:0] f;
      f = filler();
      f[15:8] = addr;
      send_request(OP_READ, f);
   endtask

   task automatic write_reg(input logic [7:0] addr, input logic [7:0] value);
      logic [39:0] f;
      f = filler();
      f[15:8] = addr;
      f[23:16] = value;
      send_request(OP_WRITE, f);
   endtask

   task automatic press(input logic [7:0] buttons);
      logic [39:0] f;
      f = filler();
      f[31:24] = buttons;
      send_request(OP_BUTTON, f);
   endtask

   task automatic check_irq(input logic ime);
      logic [39:0] f;
      f = filler();
      f[32] = ime;
      send_request(OP_CHECK, f);
   endtask

   // mostly the mapped registers, sometimes anywhere in the page
   function automatic logic [7:0] pick_address();
      if ($urandom_range(0, 99) >= 88) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 6))
         0: return ADDR_JOYP;
         1: return ADDR_DIV;
         2: return ADDR_TIMA;
         3: return ADDR_TMA;
         4: return ADDR_TAC;
         5: return ADDR_IF;
         default: return ADDR_IE;
      endcase
   endfunction

   // response back-pressure: random stalls between runs of ready
   initial begin
      int unsigned stall;
      forever begin
         stall = idle_gap();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      int unsigned r;
      logic [7:0]  addr;
      logic [7:0]  value;
      logic [5:0]  cycles;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, unmapped space and unknown opcodes
      read_reg(ADDR_JOYP);
      read_reg(ADDR_TAC);
      read_reg(8'h80);
      write_reg(8'h10, 8'h55);
      send_request(OP_CHECK + 3'd1, filler());
      send_request(OP_CHECK + 3'd3, filler());
      // timer overflow with the fastest period, video requests after the step
      write_reg(ADDR_IE, 8'hFF);
      write_reg(ADDR_TMA, 8'hFE);
      write_reg(ADDR_TIMA, 8'hFD);
      tick(6'd63, 1'b1, 1'b0);         // timer disabled, so only the divider moves; vblank is still requested
      write_reg(ADDR_TAC, 8'h05);
      tick(6'd63, 1'b0, 1'b1);
      read_reg(ADDR_TIMA);
      // report only, then take vblank, stat and timer in priority order
      check_irq(1'b0);
      check_irq(1'b1);
      check_irq(1'b1);
      check_irq(1'b1);
      // joypad press and both select lines
      press(8'hA5);
      write_reg(ADDR_JOYP, 8'h20);
      read_reg(ADDR_JOYP);
      write_reg(ADDR_JOYP, 8'h10);
      read_reg(ADDR_JOYP);
      // period change keeps the accumulator, next tick catches up
      write_reg(ADDR_TAC, 8'h04);
      tick(6'd40, 1'b0, 1'b0);
      write_reg(ADDR_TAC, 8'h05);
      tick(6'd0, 1'b0, 1'b0);
      write_reg(ADDR_DIV, 8'h00);
      read_reg(ADDR_DIV);

      // random: ticks lead, timer mostly on; register traffic, presses, checks and bad opcodes
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            cycles = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 32))
                                                  : 6'($urandom_range(33, 63));
            tick(cycles, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
         end else if (r < 60) begin
            read_reg(pick_address());
         end else if (r < 80) begin
            addr = pick_address();
            value = 8'($urandom);
            // keep the timer running most of the time and overflows frequent
            if (addr == ADDR_TAC && $urandom_range(0, 3) != 0) value[2] = 1'b1;
            if (addr == ADDR_TMA && $urandom_range(0, 1) == 0) value[7:4] = 4'hF;
            write_reg(addr, value);
         end else if (r < 88) begin
            press(8'($urandom));
         end else if (r < 98) begin
            check_irq($urandom_range(0, 3) != 0);
         end else begin
            send_request(OP_CHECK + 3'($urandom_range(1, 3)), filler());
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // drain: every predicted response must arrive, then let the unit settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS timer_irq_joypad_io_unit");
      end else begin
         $display("FAIL timer_irq_joypad_io_unit");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #30_000_000;
      $display("FAIL timer_irq_joypad_io_unit");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tij_pkg.sv
hw/rtl/tij_timer_unit.sv
hw/rtl/tij_irq_unit.sv
hw/rtl/timer_irq_joypad_io_unit.sv
hw/rtl/tij_checker.sv
sim/timer_irq_joypad_io_checker.sv
sim/tb_timer_irq_joypad_io_unit.sv
